// File: hdl/tte_pkg.sv
// shared constants, types and helpers of the text terminal cell engine
package tte_pkg;

    localparam int COLUMNS  = 80;
    localparam int ROWS     = 25;
    localparam int TAB_STEP = 4;

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int TSUM_W = $clog2(COLUMNS + TAB_STEP);

    localparam int OP_W       = 3;
    localparam int CHAR_W     = 8;
    localparam int CELL_COL_W = 7;
    localparam int CELL_ROW_W = 5;
    localparam int CELL_W     = 16;
    localparam int POS_W      = 11;
    localparam int COLOR_W    = 8;

    localparam logic [OP_W-1:0] OP_PUT   = 3'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd1;
    localparam logic [OP_W-1:0] OP_UP    = 3'd2;
    localparam logic [OP_W-1:0] OP_DOWN  = 3'd3;
    localparam logic [OP_W-1:0] OP_LEFT  = 3'd4;
    localparam logic [OP_W-1:0] OP_RIGHT = 3'd5;
    localparam logic [OP_W-1:0] OP_READ  = 3'd6;
    localparam logic [OP_W-1:0] OP_WRITE = 3'd7;

    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

    localparam logic [CELL_W-1:0]  RESET_CELL  = 16'h0720;
    localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] position;
        logic             rd_sel;
    } resp_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
        return ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c);
    endfunction

endpackage

// File: hdl/tte_if.sv
// item channels of the text terminal cell engine
interface tte_in_if
    import tte_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [OP_W-1:0]       operation;
    logic [CHAR_W-1:0]     char_code;
    logic [CELL_COL_W-1:0] cell_column;
    logic [CELL_ROW_W-1:0] cell_row;
    logic [CELL_W-1:0]     cell_value;

    modport source (output valid, operation, char_code, cell_column, cell_row, cell_value,
                    input ready);
    modport sink (input valid, operation, char_code, cell_column, cell_row, cell_value,
                  output ready);
endinterface

interface tte_out_if
    import tte_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [POS_W-1:0]  cursor_position;
    logic [CELL_W-1:0] read_data;

    modport source (output valid, cursor_position, read_data, input ready);
    modport sink (input valid, cursor_position, read_data, output ready);
endinterface

// File: hdl/tte_cell_ram.sv
// generic single-write, single-read synchronous ram
module tte_cell_ram #(
    parameter int DEPTH = 2000,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hdl/tte_seq.sv
// sequencer: cursor, color register, item decode and screen passes
module tte_seq
    import tte_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    tte_in_if.sink             cmd,
    input  logic               cfg_write,
    input  logic [COLOR_W-1:0] cfg_data,
    input  logic               resp_take,
    output resp_t              resp,
    output mem_req_t           mem_req
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RESP   = 2'd1;
    localparam logic [1:0] ST_SCROLL = 2'd2;
    localparam logic [1:0] ST_FILL   = 2'd3;

    localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] LAST_COL  = COL_W'(COLUMNS - 1);
    localparam logic [CNT_W-1:0] COPY_LEN  = CNT_W'(CELLS - COLUMNS);
    localparam logic [CNT_W-1:0] LAST_CELL = CNT_W'(CELLS - 1);

    logic [1:0]         state_reg, state_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               fill_reset_reg, fill_reset_next;
    logic               rd_sel_reg, rd_sel_next;
    logic [COLOR_W-1:0] color_reg;

    logic               accept;
    logic               wrap;
    logic               addr_ok;
    logic [TSUM_W-1:0]  tab_sum;
    logic [ROW_W-1:0]   bs_row;
    logic [COL_W-1:0]   bs_col;
    logic [ADDR_W-1:0]  cur_addr;
    logic [ADDR_W-1:0]  in_addr;
    logic [CELL_W-1:0]  blank_cell;

    assign cmd.ready  = (state_reg == ST_IDLE);
    assign accept     = cmd.valid && cmd.ready;
    assign blank_cell = {color_reg, CH_SPACE};
    assign cur_addr   = cell_addr(row_reg, col_reg);
    assign tab_sum    = TSUM_W'(col_reg) + TSUM_W'(TAB_STEP);
    assign addr_ok    = (32'(cmd.cell_column) < COLUMNS) && (32'(cmd.cell_row) < ROWS);
    assign in_addr    = cell_addr(ROW_W'(cmd.cell_row), COL_W'(cmd.cell_column));

    // backspace target, wraps to the previous row and stops at the top-left corner
    always_comb
    begin
        bs_row = row_reg;
        bs_col = col_reg;
        if (col_reg != '0)
        begin
            bs_col = col_reg - COL_W'(1);
        end
        else if (row_reg != '0)
        begin
            bs_row = row_reg - ROW_W'(1);
            bs_col = LAST_COL;
        end
    end

    assign resp.valid    = (state_reg == ST_RESP);
    assign resp.position = POS_W'(cur_addr);
    assign resp.rd_sel   = rd_sel_reg;

    always_comb
    begin
        state_next      = state_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        cnt_next        = cnt_reg;
        fill_reset_next = fill_reset_reg;
        rd_sel_next     = rd_sel_reg;
        wrap            = 1'b0;
        mem_req         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next  = ST_RESP;
                    rd_sel_next = 1'b0;
                    case (cmd.operation)
                        OP_PUT:
                        begin
                            case (cmd.char_code)
                                CH_NEWLINE:
                                begin
                                    wrap = 1'b1;
                                end
                                CH_RETURN:
                                begin
                                    col_next = '0;
                                end
                                CH_TAB:
                                begin
                                    if (tab_sum >= TSUM_W'(COLUMNS))
                                    begin
                                        wrap = 1'b1;
                                    end
                                    else
                                    begin
                                        col_next = COL_W'(tab_sum);
                                    end
                                end
                                CH_BACKSPACE:
                                begin
                                    row_next      = bs_row;
                                    col_next      = bs_col;
                                    mem_req.we    = 1'b1;
                                    mem_req.waddr = cell_addr(bs_row, bs_col);
                                    mem_req.wdata = blank_cell;
                                end
                                default:
                                begin
                                    mem_req.we    = 1'b1;
                                    mem_req.waddr = cur_addr;
                                    mem_req.wdata = {color_reg, cmd.char_code};
                                    if (col_reg == LAST_COL)
                                    begin
                                        wrap = 1'b1;
                                    end
                                    else
                                    begin
                                        col_next = col_reg + COL_W'(1);
                                    end
                                end
                            endcase
                        end
                        OP_CLEAR:
                        begin
                            row_next        = '0;
                            col_next        = '0;
                            cnt_next        = '0;
                            fill_reset_next = 1'b0;
                            state_next      = ST_FILL;
                        end
                        OP_UP:
                        begin
                            if (row_reg != '0)
                            begin
                                row_next = row_reg - ROW_W'(1);
                            end
                        end
                        OP_DOWN:
                        begin
                            if (row_reg != LAST_ROW)
                            begin
                                row_next = row_reg + ROW_W'(1);
                            end
                        end
                        OP_LEFT:
                        begin
                            if (col_reg != '0)
                            begin
                                col_next = col_reg - COL_W'(1);
                            end
                        end
                        OP_RIGHT:
                        begin
                            if (col_reg != LAST_COL)
                            begin
                                col_next = col_reg + COL_W'(1);
                            end
                        end
                        OP_READ:
                        begin
                            rd_sel_next   = addr_ok;
                            mem_req.re    = addr_ok;
                            mem_req.raddr = in_addr;
                        end
                        OP_WRITE:
                        begin
                            mem_req.we    = addr_ok;
                            mem_req.waddr = in_addr;
                            mem_req.wdata = cmd.cell_value;
                        end
                        default:
                        begin
                        end
                    endcase

                    // move to the next line, scrolling from the bottom row
                    if (wrap)
                    begin
                        col_next = '0;
                        if (row_reg == LAST_ROW)
                        begin
                            cnt_next   = '0;
                            state_next = ST_SCROLL;
                        end
                        else
                        begin
                            row_next = row_reg + ROW_W'(1);
                        end
                    end
                end
            end
            ST_RESP:
            begin
                if (resp_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCROLL:
            begin
                // read one row ahead, write back what the previous cycle read
                mem_req.re    = (cnt_reg < COPY_LEN);
                mem_req.raddr = cnt_reg[ADDR_W-1:0] + ADDR_W'(COLUMNS);
                mem_req.we    = (cnt_reg != '0);
                mem_req.waddr = cnt_reg[ADDR_W-1:0] - ADDR_W'(1);
                if (cnt_reg == COPY_LEN)
                begin
                    fill_reset_next = 1'b0;
                    state_next      = ST_FILL;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_FILL:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = cnt_reg[ADDR_W-1:0];
                mem_req.wdata = fill_reset_reg ? RESET_CELL : blank_cell;
                if (cnt_reg == LAST_CELL)
                begin
                    fill_reset_next = 1'b0;
                    state_next      = fill_reset_reg ? ST_IDLE : ST_RESP;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // write data of the scroll copy is the ram output, patched in by the top level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_FILL;
            row_reg        <= '0;
            col_reg        <= '0;
            cnt_reg        <= '0;
            fill_reset_reg <= 1'b1;
            rd_sel_reg     <= 1'b0;
            color_reg      <= RESET_COLOR;
        end
        else
        begin
            state_reg      <= state_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            cnt_reg        <= cnt_next;
            fill_reset_reg <= fill_reset_next;
            rd_sel_reg     <= rd_sel_next;
            if (cfg_write)
            begin
                color_reg <= cfg_data;
            end
        end
    end

endmodule

// File: hdl/text_terminal_cell_engine.sv
// top level: text terminal cell engine with cell store and result register
//
//  channel   dir  handshake         payload
//  cmd       in   valid / ready     operation, char_code, cell_column, cell_row, cell_value
//  result    out  valid / ready     cursor_position, read_data
//  cfg       in   cfg_write         cfg_data (text color)
//
// an item makes its decode and cell access in the accept cycle, its result load in the response state
// a clear blanks every cell, a scroll moves the rows up and blanks the last row; no item is taken meanwhile
// after reset a clearing pass fills all CELLS (2000) cells of the store, cmd.ready stays low
// the result register decouples the output; a stalled result holds the sequencer in its
// response state, so the next item is taken once the pending result has been loaded
module text_terminal_cell_engine
    import tte_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    tte_in_if.sink             cmd,
    tte_out_if.source          result,
    input  logic               cfg_write,
    input  logic [COLOR_W-1:0] cfg_data
);

    resp_t             resp;
    mem_req_t          seq_req;
    mem_req_t          mem_req;
    logic              resp_take;
    logic [CELL_W-1:0] rdata;
    logic              scroll_reg;
    logic              scroll_active;

    logic              out_valid_reg;
    logic [POS_W-1:0]  out_pos_reg;
    logic [CELL_W-1:0] out_data_reg;

    tte_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .resp_take (resp_take),
        .resp      (resp),
        .mem_req   (seq_req)
    );

    assign scroll_active = scroll_reg;

    // the scroll copy writes back what the ram read in the cycle before
    always_comb
    begin
        mem_req = seq_req;
        if (scroll_active)
        begin
            mem_req.wdata = rdata;
        end
    end

    tte_cell_ram #(
        .DEPTH (CELLS),
        .WIDTH (CELL_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (rdata)
    );

    // tracks the copy phase of a scroll: entered from an accepted item, left at the fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scroll_reg <= 1'b0;
        end
        else if (seq_req.re && !cmd.ready && !resp.valid)
        begin
            scroll_reg <= 1'b1;
        end
        else if (!seq_req.re)
        begin
            scroll_reg <= 1'b0;
        end
    end

    assign resp_take = resp.valid && (!out_valid_reg || result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (resp_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (resp_take)
        begin
            out_pos_reg  <= resp.position;
            out_data_reg <= resp.rd_sel ? rdata : '0;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.cursor_position = out_pos_reg;
    assign result.read_data       = out_data_reg;

`ifndef SYNTHESIS
    a_no_same_cell: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
        else $error("cell store read and write hit the same entry");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> !cmd.ready)
        else $error("item accepted while the previous one is in flight");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        resp.valid |-> (32'(resp.position) < CELLS))
        else $error("cursor left the screen");
`endif

endmodule

// File: tb/testbench.sv
// self-checking testbench of the text terminal cell engine
module testbench;
    import tte_pkg::*;

    typedef struct packed {
        logic [OP_W-1:0]       op;
        logic [CHAR_W-1:0]     ch;
        logic [CELL_COL_W-1:0] col;
        logic [CELL_ROW_W-1:0] row;
        logic [CELL_W-1:0]     val;
    } term_item_t;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [CELL_W-1:0] data;
    } term_result_t;

    // one directed item; known rows carry a hand-typed result
    typedef struct packed {
        term_item_t   item;
        bit           known;
        term_result_t res;
    } dir_row_t;

    localparam int DIR_N   = 25;
    localparam int PHASES  = 5;
    localparam int PHASE_N = 200;

    localparam dir_row_t DIRECTED [0:DIR_N-1] = '{
        // fresh screen: both corners blank, out-of-range read gives zero
        '{'{OP_READ,  8'h00,        7'd0,   5'd0,  16'h0000}, 1'b1, '{11'd0,  RESET_CELL}},
        '{'{OP_READ,  8'h00,        7'd79,  5'd24, 16'h0000}, 1'b1, '{11'd0,  RESET_CELL}},
        '{'{OP_READ,  8'h00,        7'd127, 5'd31, 16'h0000}, 1'b1, '{11'd0,  16'h0000}},
        // clamps and backspace at the top-left corner, then printing, tab, return and newline
        '{'{OP_UP,    8'h00,        7'd0,   5'd0,  16'h0000}, 1'b1, '{11'd0,  16'h0000}},
        '{'{OP_LEFT,  8'h00,        7'd0,   5'd0,  16'h0000}, 1'b1, '{11'd0,  16'h0000}},
        '{'{OP_PUT,   CH_BACKSPACE, 7'd0,   5'd0,  16'h0000}, 1'b1, '{11'd0,  16'h0000}},
        '{'{OP_PUT,   8'h41,        7'd0,   5'd0,  16'h0000}, 1'b1, '{11'd1,  16'h0000}},
        '{'{OP_PUT,   8'hFF,        7'd0,   5'd0,  16'h0000}, 1'b1, '{11'd2,  16'h0000}},
        '{'{OP_PUT,   8'h00,        7'd0,   5'd0,  16'h0000}, 1'b1, '{11'd3,  16'h0000}},
        '{'{OP_PUT,   CH_TAB,       7'd0,   5'd0,  16'h0000}, 1'b1, '{11'd7,  16'h0000}},
        '{'{OP_PUT,   CH_RETURN,    7'd0,   5'd0,  16'h0000}, 1'b1, '{11'd0,  16'h0000}},
        '{'{OP_PUT,   CH_NEWLINE,   7'd0,   5'd0,  16'h0000}, 1'b1, '{11'd80, 16'h0000}},
        // backspace at column 0 goes to the end of the row above
        '{'{OP_PUT,   CH_BACKSPACE, 7'd0,   5'd0,  16'h0000}, 1'b1, '{11'd79, 16'h0000}},
        '{'{OP_RIGHT, 8'h00,        7'd0,   5'd0,  16'h0000}, 1'b1, '{11'd79, 16'h0000}},
        '{'{OP_PUT,   8'h42,        7'd0,   5'd0,  16'h0000}, 1'b1, '{11'd80, 16'h0000}},
        '{'{OP_READ,  8'h00,        7'd79,  5'd0,  16'h0000}, 1'b0, '{11'd0,  16'h0000}},
        '{'{OP_WRITE, 8'h00,        7'd79,  5'd24, 16'hFFFF}, 1'b1, '{11'd80, 16'h0000}},
        // writes outside the screen are dropped
        '{'{OP_WRITE, 8'h00,        7'd80,  5'd0,  16'h1234}, 1'b1, '{11'd80, 16'h0000}},
        '{'{OP_WRITE, 8'h00,        7'd0,   5'd25, 16'h0000}, 1'b1, '{11'd80, 16'h0000}},
        '{'{OP_READ,  8'h00,        7'd79,  5'd24, 16'h0000}, 1'b0, '{11'd0,  16'h0000}},
        '{'{OP_READ,  8'h00,        7'd0,   5'd0,  16'h0000}, 1'b0, '{11'd0,  16'h0000}},
        '{'{OP_READ,  8'h00,        7'd1,   5'd0,  16'h0000}, 1'b0, '{11'd0,  16'h0000}},
        '{'{OP_DOWN,  8'h00,        7'd0,   5'd0,  16'h0000}, 1'b0, '{11'd0,  16'h0000}},
        '{'{OP_CLEAR, 8'h00,        7'd0,   5'd0,  16'h0000}, 1'b1, '{11'd0,  16'h0000}},
        '{'{OP_READ,  8'h00,        7'd79,  5'd24, 16'h0000}, 1'b0, '{11'd0,  16'h0000}}
    };

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [COLOR_W-1:0] cfg_data;

    tte_in_if  cmd_ch ();
    tte_out_if res_ch ();

    text_terminal_cell_engine i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .result    (res_ch),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    // screen model and cursor
    logic [CELL_W-1:0]  screen_model [0:CELLS-1];
    int                 row_now;
    int                 col_now;
    logic [COLOR_W-1:0] attr_now;

    term_result_t pending [$];
    bit           src_idle_on;
    bit           sink_stall_on;
    int           errors;
    int           items_sent;
    int           results_seen;
    int           scrolls;
    int           clears;
    int           colors_set;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic void advance_row();
        col_now = 0;
        row_now++;
        if (row_now >= ROWS)
        begin
            for (int i = 0; i < CELLS - COLUMNS; i++)
                screen_model[i] = screen_model[i + COLUMNS];
            for (int i = CELLS - COLUMNS; i < CELLS; i++)
                screen_model[i] = {attr_now, CH_SPACE};
            row_now = ROWS - 1;
            scrolls++;
        end
    endfunction

    function automatic term_result_t step_terminal(term_item_t it);
        term_result_t r;
        logic         in_range;
        int           idx;
        r.data   = '0;
        in_range = (int'(it.col) < COLUMNS) && (int'(it.row) < ROWS);
        idx      = int'(it.row) * COLUMNS + int'(it.col);
        case (it.op)
            OP_PUT:
            begin
                case (it.ch)
                    CH_NEWLINE: advance_row();
                    CH_RETURN:  col_now = 0;
                    CH_TAB:
                    begin
                        col_now += TAB_STEP;
                        if (col_now >= COLUMNS)
                            advance_row();
                    end
                    CH_BACKSPACE:
                    begin
                        if (col_now > 0)
                            col_now--;
                        else if (row_now > 0)
                        begin
                            row_now--;
                            col_now = COLUMNS - 1;
                        end
                        screen_model[row_now * COLUMNS + col_now] = {attr_now, CH_SPACE};
                    end
                    default:
                    begin
                        screen_model[row_now * COLUMNS + col_now] = {attr_now, it.ch};
                        col_now++;
                        if (col_now >= COLUMNS)
                            advance_row();
                    end
                endcase
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < CELLS; i++)
                    screen_model[i] = {attr_now, CH_SPACE};
                row_now = 0;
                col_now = 0;
                clears++;
            end
            OP_UP:    if (row_now > 0) row_now--;
            OP_DOWN:  if (row_now < ROWS - 1) row_now++;
            OP_LEFT:  if (col_now > 0) col_now--;
            OP_RIGHT: if (col_now < COLUMNS - 1) col_now++;
            OP_READ:  if (in_range) r.data = screen_model[idx];
            default:  if (in_range) screen_model[idx] = it.val;
        endcase
        r.pos = POS_W'(row_now * COLUMNS + col_now);
        return r;
    endfunction

    function automatic term_item_t random_item();
        term_item_t it;
        int         sel;
        it.op  = OP_W'($urandom_range(0, 7));
        it.ch  = CHAR_W'($urandom);
        it.col = CELL_COL_W'($urandom);
        it.row = CELL_ROW_W'($urandom);
        it.val = CELL_W'($urandom);
        sel    = $urandom_range(0, 99);
        if (sel < 55)
        begin
            it.op = OP_PUT;
            case ($urandom_range(0, 19))
                0, 1:    it.ch = CH_NEWLINE;
                2:       it.ch = CH_TAB;
                3:       it.ch = CH_BACKSPACE;
                4:       it.ch = CH_RETURN;
                default: ;
            endcase
        end
        else if (sel < 78)
        begin
            it.op = (sel < 71) ? OP_READ : OP_WRITE;
            // mostly valid addresses, often on the cursor row to see fresh text
            case ($urandom_range(0, 9))
                0:       ;
                1, 2, 3:
                begin
                    it.row = CELL_ROW_W'(row_now);
                    it.col = CELL_COL_W'($urandom_range(0, COLUMNS - 1));
                end
                default:
                begin
                    it.row = CELL_ROW_W'($urandom_range(0, ROWS - 1));
                    it.col = CELL_COL_W'($urandom_range(0, COLUMNS - 1));
                end
            endcase
        end
        else if (sel < 94)
            it.op = OP_W'(OP_UP + OP_W'((sel - 78) % 4));
        else if (sel < 95)
            it.op = OP_CLEAR;
        return it;
    endfunction

    task automatic push_cmd(term_item_t it, bit known, term_result_t typed);
        term_result_t r;
        if (src_idle_on && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(0, 18)) @(negedge clk);
        end
        @(negedge clk);
        cmd_ch.valid       <= 1'b1;
        cmd_ch.operation   <= it.op;
        cmd_ch.char_code   <= it.ch;
        cmd_ch.cell_column <= it.col;
        cmd_ch.cell_row    <= it.row;
        cmd_ch.cell_value  <= it.val;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        r = step_terminal(it);
        pending.push_back(known ? typed : r);
        items_sent++;
    endtask

    task automatic drain_results();
        while (pending.size() != 0)
            @(posedge clk);
        repeat (8) @(negedge clk);
    endtask

    // result side back-pressure
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_stall_on && $urandom_range(0, 7) == 0)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 18)) @(negedge clk);
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        term_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            results_seen++;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: result with no item pending, position %0d data %h",
                         $time, res_ch.cursor_position, res_ch.read_data);
            end
            else
            begin
                want = pending.pop_front();
                if (res_ch.cursor_position !== want.pos)
                begin
                    errors++;
                    $display("%0t: cursor_position mismatch, expected %0d, actual %0d",
                             $time, want.pos, res_ch.cursor_position);
                end
                if (res_ch.read_data !== want.data)
                begin
                    errors++;
                    $display("%0t: read_data mismatch, expected %h, actual %h",
                             $time, want.data, res_ch.read_data);
                end
            end
        end
    end

    initial
    begin
        #20000000;
        $display("timeout with %0d results outstanding", pending.size());
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        term_item_t         it;
        logic [COLOR_W-1:0] color;
        int                 sent;
        int                 burst;
        rst_n              = 1'b0;
        cfg_write          = 1'b0;
        cfg_data           = '0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.operation   = OP_PUT;
        cmd_ch.char_code   = '0;
        cmd_ch.cell_column = '0;
        cmd_ch.cell_row    = '0;
        cmd_ch.cell_value  = '0;
        errors             = 0;
        items_sent         = 0;
        results_seen       = 0;
        scrolls            = 0;
        clears             = 0;
        colors_set         = 0;
        src_idle_on        = 1'b1;
        sink_stall_on      = 1'b1;
        for (int i = 0; i < CELLS; i++)
            screen_model[i] = RESET_CELL;
        row_now  = 0;
        col_now  = 0;
        attr_now = RESET_COLOR;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_N; i++)
            push_cmd(DIRECTED[i].item, DIRECTED[i].known, DIRECTED[i].res);

        for (int p = 0; p < PHASES; p++)
        begin
            @(negedge clk);
            cmd_ch.valid <= 1'b0;
            drain_results();
            case (p)
                0:       color = 8'h00;
                1:       color = 8'hFF;
                PHASES - 1: color = RESET_COLOR;
                default: color = COLOR_W'($urandom);
            endcase
            cfg_write <= 1'b1;
            cfg_data  <= color;
            @(posedge clk);
            attr_now = color;
            colors_set++;
            @(negedge clk);
            cfg_write <= 1'b0;
            // the last phase runs at full rate on both sides
            src_idle_on   = (p < PHASES - 1);
            sink_stall_on = (p < PHASES - 1);
            sent = 0;
            while (sent < PHASE_N)
            begin
                if ($urandom_range(0, 99) < 2)
                begin
                    // run to the bottom edge: newlines scroll, cursor down clamps
                    burst = $urandom_range(20, 30);
                    for (int k = 0; k < burst; k++)
                    begin
                        it    = random_item();
                        it.op = (burst % 2 == 0) ? OP_PUT : OP_DOWN;
                        it.ch = CH_NEWLINE;
                        push_cmd(it, 1'b0, '0);
                    end
                    sent += burst;
                end
                else
                begin
                    push_cmd(random_item(), 1'b0, '0);
                    sent++;
                end
            end
        end

        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        drain_results();

        $display("covered %0d items and %0d results, %0d scrolls, %0d clears",
                 items_sent, results_seen, scrolls, clears);
        $display("text color written %0d times, %0d mismatches", colors_set, errors);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
